// File: rtl/t2me_pkg.sv
package t2me_pkg;

   localparam int unsigned ReqDataWidth = 136;
   localparam int unsigned RspDataWidth = 80;

   localparam logic [3:0] RegSp = 4'd13;
   localparam logic [3:0] RegPc = 4'd15;

   // opcode patterns on the first halfword, low nibble masked
   localparam logic [15:0] OpfRev      = 16'hfa90;
   localparam logic [15:0] OpfLdrW     = 16'hf850;
   localparam logic [15:0] OpfLdrB     = 16'hf810;
   localparam logic [15:0] OpfLdrH     = 16'hf830;
   localparam logic [15:0] OpfLdrSB    = 16'hf910;
   localparam logic [15:0] OpfLdrSH    = 16'hf930;
   localparam logic [15:0] OpfPldImm   = 16'hf890;
   localparam logic [15:0] OpfPliImm   = 16'hf990;
   localparam logic [15:0] HintFirst   = 16'hf3af;
   localparam logic [15:0] RevMask     = 16'hf0c0;
   localparam logic [15:0] RevMatch    = 16'hf080;
   localparam logic [15:0] PlMaskA     = 16'h0fc0;
   localparam logic [15:0] PlMaskB     = 16'h0f00;
   localparam logic [15:0] PlMatchB    = 16'h0c00;

   // reversal sub-opcodes in second halfword bits 7:4
   localparam logic [3:0] RopRev   = 4'd8;
   localparam logic [3:0] RopRev16 = 4'd9;
   localparam logic [3:0] RopRevsh = 4'd11;

   // hint numbers
   localparam logic [7:0] HintNop   = 8'd0;
   localparam logic [7:0] HintYield = 8'd1;
   localparam logic [7:0] HintWfe   = 8'd2;
   localparam logic [7:0] HintWfi   = 8'd3;
   localparam logic [7:0] HintSev   = 8'd4;

   localparam logic [2:0] SizeNone = 3'd0;
   localparam logic [2:0] SizeByte = 3'd1;
   localparam logic [2:0] SizeHalf = 3'd2;
   localparam logic [2:0] SizeWord = 3'd4;

   typedef enum logic {
      OP_INSTR  = 1'b0,
      OP_RETURN = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] first_half;
      logic [15:0] second_half;
      logic [31:0] pc_value;
      logic [31:0] operand_value;
      logic [31:0] load_data;
      logic        load_ok;
   } item_type;

   typedef struct packed {
      logic        handled;
      logic        reg_write;
      logic [3:0]  reg_index;
      logic [31:0] reg_value;
      logic        state_fault;
      logic        load_request;
      logic [31:0] load_address;
      logic [2:0]  load_size;
      logic        sleep_entered;
      logic        wait_interrupt;
      logic        event_flag;
   } result_type;

   typedef struct packed {
      logic       event_latch;
      logic       load_pending;
      logic [3:0] load_target;
      logic       load_signed;
      logic [2:0] load_bytes;
   } state_type;

endpackage

// File: rtl/t2me_exec.sv
module t2me_exec
   import t2me_pkg::*;
(
   input  item_type   item,
   input  state_type  state,
   output result_type result,
   output state_type  state_next
);

   logic [15:0] f;
   logic [15:0] s;
   logic [15:0] opf;
   logic [3:0]  rop;
   logic [7:0]  hint;
   logic [3:0]  rd;
   logic [31:0] src;
   logic [31:0] data;
   logic        is_rev;
   logic        is_hint_frame;
   logic        hint_ok;
   logic        is_pl;
   logic        is_lit;
   logic [2:0]  lit_size;

   always_comb begin
      f    = item.first_half;
      s    = item.second_half;
      opf  = {f[15:4], 4'h0};
      rop  = s[7:4];
      hint = s[7:0];
      rd   = s[11:8];
      src  = item.operand_value;

      is_rev = (opf == OpfRev) && ((s & RevMask) == RevMatch)
               && (rop == RopRev || rop == RopRev16 || rop == RopRevsh)
               && !(f[3:0] == RegSp || f[3:0] == RegPc)
               && !(rd == RegSp || rd == RegPc);

      is_hint_frame = (f == HintFirst) && (s[15:8] == 8'h80);
      hint_ok = (hint == HintNop) || (hint == HintYield) || (hint[7:4] == 4'hf)
                || (hint == HintWfe) || (hint == HintWfi) || (hint == HintSev);

      is_pl = (s[15:12] == 4'hf)
              && ((opf == OpfPldImm) || (opf == OpfPliImm)
                  || (((opf == OpfLdrB) || (opf == OpfLdrSB))
                      && (((s & PlMaskA) == 16'h0000)
                          || ((s & PlMaskB) == PlMatchB))));

      is_lit = (f[3:0] == RegPc)
               && ((opf == OpfLdrW) || (opf == OpfLdrB) || (opf == OpfLdrH)
                   || (opf == OpfLdrSB) || (opf == OpfLdrSH))
               && !((s[15:12] == 4'hf) && (opf != OpfLdrW));

      if (opf == OpfLdrW) begin
         lit_size = SizeWord;
      end else if ((opf == OpfLdrH) || (opf == OpfLdrSH)) begin
         lit_size = SizeHalf;
      end else begin
         lit_size = SizeByte;
      end

      // masking and sign extension of returned data
      data = item.load_data;
      if (state.load_bytes == SizeByte) begin
         data = {24'h0, data[7:0]};
      end else if (state.load_bytes == SizeHalf) begin
         data = {16'h0, data[15:0]};
      end
      if (state.load_signed && (state.load_bytes != SizeWord)) begin
         if (state.load_bytes == SizeByte) begin
            data = {{24{data[7]}}, data[7:0]};
         end else begin
            data = {{16{data[15]}}, data[15:0]};
         end
      end

      result     = '0;
      state_next = state;

      case (item.op)
         OP_RETURN: begin
            if (state.load_pending) begin
               result.handled = 1'b1;
               if (item.load_ok) begin
                  if (state.load_target == RegPc) begin
                     if (!data[0]) begin
                        result.state_fault = 1'b1;
                     end else begin
                        result.reg_write = 1'b1;
                        result.reg_index = RegPc;
                        result.reg_value = {data[31:1], 1'b0};
                     end
                  end else begin
                     result.reg_write = 1'b1;
                     result.reg_index = state.load_target;
                     result.reg_value = data;
                  end
               end
               state_next.load_pending = 1'b0;
            end
         end
         OP_INSTR: begin
            if (is_rev) begin
               result.handled   = 1'b1;
               result.reg_write = 1'b1;
               result.reg_index = rd;
               case (rop)
                  RopRev:   result.reg_value = {src[7:0], src[15:8], src[23:16], src[31:24]};
                  RopRev16: result.reg_value = {src[23:16], src[31:24], src[7:0], src[15:8]};
                  default:  result.reg_value = {{16{src[7]}}, src[7:0], src[15:8]};
               endcase
            end else if (is_hint_frame && hint_ok) begin
               result.handled = 1'b1;
               if (hint == HintWfe) begin
                  result.sleep_entered    = !state.event_latch;
                  state_next.event_latch  = 1'b0;
               end else if (hint == HintWfi) begin
                  result.wait_interrupt = 1'b1;
               end else if (hint == HintSev) begin
                  state_next.event_latch = 1'b1;
               end
            end else if (is_pl) begin
               result.handled = 1'b1;
            end else if (is_lit) begin
               result.handled      = 1'b1;
               result.load_request = 1'b1;
               result.load_size    = lit_size;
               result.load_address = {item.pc_value[31:2], 2'b00} - {20'h0, s[11:0]};
               state_next.load_pending = 1'b1;
               state_next.load_target  = s[15:12];
               state_next.load_signed  = (opf == OpfLdrSB) || (opf == OpfLdrSH);
               state_next.load_bytes   = lit_size;
            end
         end
         default: begin
         end
      endcase

      result.event_flag = state_next.event_latch;
   end

endmodule

// File: rtl/thumb2_misc_execute.sv
// an accepted request transaction passes the input register, the execute pass and the
// result register before it leaves as its response transaction
// throughput: one transaction per cycle unless stalled, set by the single execute pass
// reset: synchronous, active high; clears the event latch, the pending load and both
// valid flags
module thumb2_misc_execute
   import t2me_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // first_half[15:0], second_half[31:16], pc_value[63:32], operand_value[95:64],
   // load_data[127:96], load_ok[128], zero pad above
   input  logic [ReqDataWidth-1:0] req_tdata,
   // op: 0 instruction, 1 load data return
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // handled[0], reg_write[1], reg_index[5:2], reg_value[37:6], state_fault[38],
   // load_request[39], load_address[71:40], load_size[74:72], sleep_entered[75],
   // wait_interrupt[76], event_flag[77], zero pad above
   output logic [RspDataWidth-1:0] rsp_tdata
);

   // pipeline registers
   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   item_ff;
   item_type   item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;

   // architectural state of the group
   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   result_type result_comb;

   logic       out_advance;   // result register can take a new value
   logic       fire;          // item in the input register moves on
   logic       req_take;

   assign out_advance = !out_valid_ff || rsp_tready;
   assign fire        = in_valid_ff && out_advance;
   assign req_tready  = !in_valid_ff || out_advance;
   assign req_take    = req_tvalid && req_tready;

   // unpack the request payload
   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.op            = op_type'(req_tuser);
         item_in.first_half    = req_tdata[15:0];
         item_in.second_half   = req_tdata[31:16];
         item_in.pc_value      = req_tdata[63:32];
         item_in.operand_value = req_tdata[95:64];
         item_in.load_data     = req_tdata[127:96];
         item_in.load_ok       = req_tdata[128];
      end
   end

   // the execute pass
   t2me_exec u_exec (
      .item       (item_ff),
      .state      (state_ff),
      .result     (result_comb),
      .state_next (state_next)
   );

   // state only moves when an item actually leaves the input register, so order is kept
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      result_in    = fire ? result_comb : result_ff;
      state_in     = fire ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        result_ff.event_flag,
                        result_ff.wait_interrupt,
                        result_ff.sleep_entered,
                        result_ff.load_size,
                        result_ff.load_address,
                        result_ff.load_request,
                        result_ff.state_fault,
                        result_ff.reg_value,
                        result_ff.reg_index,
                        result_ff.reg_write,
                        result_ff.handled};

endmodule

// File: bench/testbench.sv
module testbench
   import t2me_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one row of the directed table: the stimulus, and where it is obvious, the result typed in
   typedef struct {
      item_type   stim;
      bit         typed;
      result_type want;
   } row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // first_half, second_half, pc_value, operand_value, load_data, load_ok, zero pad
   logic [ReqDataWidth-1:0] req_tdata;
   // op
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // handled, reg_write, reg_index, reg_value, state_fault, load_request,
   // load_address, load_size, sleep_entered, wait_interrupt, event_flag, zero pad
   logic [RspDataWidth-1:0] rsp_tdata;

   // architectural state as the predictor sees it
   state_type  arch;
   result_type expected_results[$];
   row_type    vectors[$];
   int         mismatches;
   int         rsp_count;

   // idling knobs, percent per cycle
   int         send_idle_pct;
   int         recv_stall_pct;

   // long receiver hold-off, asked for by the sender, carried out by the receiver
   int         holdoff_asked;
   int         holdoff_seen;
   int         holdoff_left;

   result_type got;
   result_type want_rsp;

   thumb2_misc_execute DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // execute-stage behaviour: updates arch and gives the single result of one transaction
   function automatic result_type predict_execute(input item_type it);
      result_type  r;
      logic [15:0] f;
      logic [15:0] s;
      logic [15:0] opf;
      logic [3:0]  rop;
      logic [3:0]  rd;
      logic [7:0]  hint;
      logic [31:0] d;
      logic [31:0] x;
      bit          done;
      r    = '0;
      f    = it.first_half;
      s    = it.second_half;
      opf  = f & 16'hfff0;
      rop  = s[7:4];
      rd   = s[11:8];
      hint = s[7:0];
      x    = it.operand_value;
      done = 1'b0;
      if (it.op == OP_RETURN) begin
         if (arch.load_pending) begin
            r.handled = 1'b1;
            if (it.load_ok) begin
               d = it.load_data;
               // trim to the access width, then sign-extend the signed forms
               if (arch.load_bytes == SizeByte) begin
                  d = arch.load_signed ? {{24{d[7]}}, d[7:0]} : {24'd0, d[7:0]};
               end else if (arch.load_bytes == SizeHalf) begin
                  d = arch.load_signed ? {{16{d[15]}}, d[15:0]} : {16'd0, d[15:0]};
               end
               if (arch.load_target == RegPc) begin
                  // even branch target: invalid state, nothing written
                  if (!d[0]) begin
                     r.state_fault = 1'b1;
                  end else begin
                     r.reg_write = 1'b1;
                     r.reg_index = RegPc;
                     r.reg_value = {d[31:1], 1'b0};
                  end
               end else begin
                  r.reg_write = 1'b1;
                  r.reg_index = arch.load_target;
                  r.reg_value = d;
               end
            end
            arch.load_pending = 1'b0;
         end
      end else begin
         // byte reversal, refused for sp and pc
         if (opf == OpfRev && (s & RevMask) == RevMatch &&
             (rop == RopRev || rop == RopRev16 || rop == RopRevsh) &&
             f[3:0] != RegSp && f[3:0] != RegPc && rd != RegSp && rd != RegPc) begin
            done        = 1'b1;
            r.handled   = 1'b1;
            r.reg_write = 1'b1;
            r.reg_index = rd;
            if (rop == RopRev) begin
               r.reg_value = {x[7:0], x[15:8], x[23:16], x[31:24]};
            end else if (rop == RopRev16) begin
               r.reg_value = {x[23:16], x[31:24], x[7:0], x[15:8]};
            end else begin
               r.reg_value = {{16{x[7]}}, x[7:0], x[15:8]};
            end
         end
         // hints
         if (!done && f == HintFirst && s[15:8] == 8'h80) begin
            if (hint == HintNop || hint == HintYield || hint[7:4] == 4'hf) begin
               done = 1'b1;
            end else if (hint == HintWfe) begin
               done              = 1'b1;
               r.sleep_entered   = !arch.event_latch;
               arch.event_latch  = 1'b0;
            end else if (hint == HintWfi) begin
               done             = 1'b1;
               r.wait_interrupt = 1'b1;
            end else if (hint == HintSev) begin
               done             = 1'b1;
               arch.event_latch = 1'b1;
            end
            if (done) r.handled = 1'b1;
         end
         // preload hints
         if (!done && s[15:12] == 4'hf) begin
            if (opf == OpfPldImm || opf == OpfPliImm) begin
               done = 1'b1;
            end else if ((opf == OpfLdrB || opf == OpfLdrSB) &&
                         ((s & PlMaskA) == 16'd0 || (s & PlMaskB) == PlMatchB)) begin
               done = 1'b1;
            end
            if (done) r.handled = 1'b1;
         end
         // literal load with subtracted offset, replaces any pending load
         if (!done && f[3:0] == 4'hf &&
             (opf == OpfLdrW || opf == OpfLdrB || opf == OpfLdrH ||
              opf == OpfLdrSB || opf == OpfLdrSH) &&
             !(s[15:12] == 4'hf && opf != OpfLdrW)) begin
            r.handled      = 1'b1;
            r.load_request = 1'b1;
            if (opf == OpfLdrW) r.load_size = SizeWord;
            else if (opf == OpfLdrH || opf == OpfLdrSH) r.load_size = SizeHalf;
            else r.load_size = SizeByte;
            r.load_address    = {it.pc_value[31:2], 2'b00} - {20'd0, s[11:0]};
            arch.load_pending = 1'b1;
            arch.load_target  = s[15:12];
            arch.load_signed  = (opf == OpfLdrSB || opf == OpfLdrSH);
            arch.load_bytes   = r.load_size;
         end
      end
      r.event_flag = arch.event_latch;
      return r;
   endfunction

   // result with only the flag fields set, everything else zero
   function automatic result_type flags_only(input bit h, input bit slp, input bit wfi,
                                             input bit ev);
      result_type r;
      r                = '0;
      r.handled        = h;
      r.sleep_entered  = slp;
      r.wait_interrupt = wfi;
      r.event_flag     = ev;
      return r;
   endfunction

   task automatic add_vector(input op_type op, input logic [15:0] f, input logic [15:0] s,
                             input logic [31:0] pc, input logic [31:0] src,
                             input logic [31:0] data, input logic ok, input bit typed,
                             input result_type want);
      row_type v;
      v.stim.op            = op;
      v.stim.first_half    = f;
      v.stim.second_half   = s;
      v.stim.pc_value      = pc;
      v.stim.operand_value = src;
      v.stim.load_data     = data;
      v.stim.load_ok       = ok;
      v.typed              = typed;
      v.want               = want;
      vectors.push_back(v);
   endtask

   // random instruction mix: mostly well-formed encodings with random content, some noise
   function automatic item_type make_random_item();
      item_type    it;
      logic [31:0] rnd;
      logic [31:0] pick;
      logic [15:0] opf;
      rnd              = $urandom;
      it.op            = OP_INSTR;
      it.first_half    = rnd[15:0];
      it.second_half   = rnd[31:16];
      it.pc_value      = $urandom;
      it.operand_value = $urandom;
      it.load_data     = $urandom;
      it.load_ok       = ($urandom_range(0, 9) != 0);
      rnd              = $urandom;
      pick             = $urandom_range(0, 99);
      if (pick < 14) begin
         // reversal, registers anywhere including sp and pc
         it.first_half  = OpfRev | {12'd0, rnd[3:0]};
         it.second_half = {4'hf, rnd[7:4], 4'd0, rnd[11:8]};
         case ($urandom_range(0, 4))
            0: it.second_half[7:4] = RopRev;
            1: it.second_half[7:4] = RopRev16;
            2: it.second_half[7:4] = RopRevsh;
            3: it.second_half[7:4] = 4'd10;
            default: it.second_half[7:4] = rnd[15:12];
         endcase
         if ($urandom_range(0, 9) == 0) it.second_half = rnd[31:16];
      end else if (pick < 30) begin
         it.first_half = HintFirst;
         case ($urandom_range(0, 7))
            0: it.second_half = {8'h80, HintNop};
            1: it.second_half = {8'h80, HintYield};
            2: it.second_half = {8'h80, HintWfe};
            3: it.second_half = {8'h80, HintWfi};
            4: it.second_half = {8'h80, HintSev};
            5: it.second_half = {12'h80f, rnd[3:0]};
            default: it.second_half = {8'h80, rnd[7:0]};
         endcase
         if ($urandom_range(0, 9) == 0) it.second_half[15:8] = rnd[23:16];
      end else if (pick < 40) begin
         case ($urandom_range(0, 3))
            0: opf = OpfPldImm;
            1: opf = OpfPliImm;
            2: opf = OpfLdrB;
            default: opf = OpfLdrSB;
         endcase
         it.first_half = opf | {12'd0, rnd[3:0]};
         case ($urandom_range(0, 2))
            0: it.second_half = {4'hf, 6'd0, rnd[9:4]};
            1: it.second_half = {8'hfc, rnd[11:4]};
            default: it.second_half = {4'hf, rnd[15:4]};
         endcase
      end else if (pick < 65) begin
         case ($urandom_range(0, 4))
            0: opf = OpfLdrW;
            1: opf = OpfLdrB;
            2: opf = OpfLdrH;
            3: opf = OpfLdrSB;
            default: opf = OpfLdrSH;
         endcase
         it.first_half = opf | 16'h000f;
         if ($urandom_range(0, 9) == 0) it.first_half[3:0] = rnd[3:0];
         if ($urandom_range(0, 7) == 0) it.second_half[15:12] = 4'hf;
      end else if (pick < 92) begin
         it.op = OP_RETURN;
      end else begin
         // noise on every field, op included
         it.op = op_type'(rnd[0]);
      end
      return it;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at response %0d: %s", rsp_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] actual);
      if (actual !== want) begin
         note_mismatch($sformatf("%s expected %h, got %h", name, want, actual));
      end
   endtask

   // offer one transaction, wait for its acceptance and queue what it should produce
   task automatic drive_item(input item_type it, input bit typed, input result_type want);
      result_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, it.load_ok, it.load_data, it.operand_value, it.pc_value,
                     it.second_half, it.first_half};
      req_tuser  <= it.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // predictor always runs so its state follows the typed-in rows too
      pred = predict_execute(it);
      expected_results.push_back(typed ? want : pred);
   endtask

   // sender stops and waits until the block has returned every outstanding response
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, plus a long hold-off when the sender asks for one
   initial begin
      rsp_tready   = 1'b0;
      holdoff_seen = 0;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_asked != holdoff_seen) begin
            holdoff_seen = holdoff_asked;
            holdoff_left = 80;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // response monitor: each accepted response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.handled        = rsp_tdata[0];
         got.reg_write      = rsp_tdata[1];
         got.reg_index      = rsp_tdata[5:2];
         got.reg_value      = rsp_tdata[37:6];
         got.state_fault    = rsp_tdata[38];
         got.load_request   = rsp_tdata[39];
         got.load_address   = rsp_tdata[71:40];
         got.load_size      = rsp_tdata[74:72];
         got.sleep_entered  = rsp_tdata[75];
         got.wait_interrupt = rsp_tdata[76];
         got.event_flag     = rsp_tdata[77];
         if (expected_results.size() == 0) begin
            note_mismatch("response with nothing expected");
         end else begin
            want_rsp = expected_results.pop_front();
            check_field("handled", 32'(want_rsp.handled), 32'(got.handled));
            check_field("reg_write", 32'(want_rsp.reg_write), 32'(got.reg_write));
            check_field("reg_index", 32'(want_rsp.reg_index), 32'(got.reg_index));
            check_field("reg_value", want_rsp.reg_value, got.reg_value);
            check_field("state_fault", 32'(want_rsp.state_fault), 32'(got.state_fault));
            check_field("load_request", 32'(want_rsp.load_request),
                        32'(got.load_request));
            check_field("load_address", want_rsp.load_address, got.load_address);
            check_field("load_size", 32'(want_rsp.load_size), 32'(got.load_size));
            check_field("sleep_entered", 32'(want_rsp.sleep_entered),
                        32'(got.sleep_entered));
            check_field("wait_interrupt", 32'(want_rsp.wait_interrupt),
                        32'(got.wait_interrupt));
            check_field("event_flag", 32'(want_rsp.event_flag), 32'(got.event_flag));
         end
         rsp_count++;
      end
   end

   // main sequence
   initial begin
      row_type row;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      arch           = '0;
      mismatches     = 0;
      rsp_count      = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_asked  = 0;

      // directed table, expectations typed in only for the obvious rows
      // load return straight after reset: nothing pending, no effect
      add_vector(OP_RETURN, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hffffffff, 1'b1,
                 1'b1, flags_only(1'b0, 1'b0, 1'b0, 1'b0));
      add_vector(OP_INSTR, HintFirst, {8'h80, HintNop}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b0));
      add_vector(OP_INSTR, HintFirst, {8'h80, HintYield}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b0));
      add_vector(OP_INSTR, HintFirst, {8'h80, HintSev}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b1));
      // wfe with the event latch set: no sleep, latch cleared
      add_vector(OP_INSTR, HintFirst, {8'h80, HintWfe}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b0));
      // wfe with no event: sleep
      add_vector(OP_INSTR, HintFirst, {8'h80, HintWfe}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b1, 1'b0, 1'b0));
      add_vector(OP_INSTR, HintFirst, {8'h80, HintWfi}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b1, 1'b0));
      // debug hint
      add_vector(OP_INSTR, HintFirst, 16'h80f0, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b0));
      // hint number not in the list
      add_vector(OP_INSTR, HintFirst, 16'h8005, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b0, 1'b0, 1'b0, 1'b0));
      // rev, rev16 on all ones, revsh with the sign from the low byte
      add_vector(OP_INSTR, 16'hfa91, 16'hf282, 32'h0, 32'h12345678, 32'h0, 1'b0,
                 1'b0, '0);
      add_vector(OP_INSTR, 16'hfa90, 16'hf090, 32'h0, 32'hffffffff, 32'h0, 1'b0,
                 1'b0, '0);
      add_vector(OP_INSTR, 16'hfa9e, 16'hfebe, 32'h0, 32'h00000080, 32'h0, 1'b0,
                 1'b0, '0);
      // reversal naming sp as destination or pc as source: refused
      add_vector(OP_INSTR, 16'hfa91, 16'hfd81, 32'h0, 32'hffffffff, 32'h0, 1'b0,
                 1'b1, flags_only(1'b0, 1'b0, 1'b0, 1'b0));
      add_vector(OP_INSTR, 16'hfa9f, 16'hf28f, 32'h0, 32'hffffffff, 32'h0, 1'b0,
                 1'b1, flags_only(1'b0, 1'b0, 1'b0, 1'b0));
      // preload instruction hint
      add_vector(OP_INSTR, OpfPliImm | 16'h000f, 16'hf123, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b1, 1'b0, 1'b0, 1'b0));
      // word load from the top of memory, largest offset
      add_vector(OP_INSTR, OpfLdrW | 16'h000f, 16'h3fff, 32'hffffffff, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      // byte load replaces the pending word load, address wraps below zero
      add_vector(OP_INSTR, OpfLdrB | 16'h000f, 16'h5004, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      // unrelated instruction while a load is pending keeps it
      add_vector(OP_INSTR, HintFirst, {8'h80, HintNop}, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      // returned data wider than the access is trimmed
      add_vector(OP_RETURN, 16'h0, 16'h0, 32'h0, 32'h0, 32'hffffffff, 1'b1, 1'b0, '0);
      add_vector(OP_INSTR, OpfLdrSH | 16'h000f, 16'h6002, 32'h00000100, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      add_vector(OP_RETURN, 16'h0, 16'h0, 32'h0, 32'h0, 32'h00008001, 1'b1, 1'b0, '0);
      // load to pc, then an even target: invalid state
      add_vector(OP_INSTR, OpfLdrW | 16'h000f, 16'hf000, 32'h00000008, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      add_vector(OP_RETURN, 16'h0, 16'h0, 32'h0, 32'h0, 32'h00002000, 1'b1, 1'b0, '0);
      // load to pc whose read faults: completed, nothing written
      add_vector(OP_INSTR, OpfLdrW | 16'h000f, 16'hf004, 32'h00000020, 32'h0, 32'h0, 1'b0,
                 1'b0, '0);
      add_vector(OP_RETURN, 16'h0, 16'h0, 32'h0, 32'h0, 32'h00001001, 1'b0, 1'b0, '0);
      // narrow literal load to pc is no load at all, and no preload either
      add_vector(OP_INSTR, OpfLdrB | 16'h000f, 16'hf800, 32'h0, 32'h0, 32'h0, 1'b0,
                 1'b1, flags_only(1'b0, 1'b0, 1'b0, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         row = vectors[i];
         drive_item(row.stim, row.typed, row.want);
      end
      wait_for_results();

      // random phases: no idling, sender idling, receiver stalling, both, none again
      for (int p = 0; p < 5; p++) begin
         case (p)
            1: begin send_idle_pct = 46; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 46; end
            3: begin send_idle_pct = 36; recv_stall_pct = 36; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         // long receiver hold-off while transactions keep coming, so the block fills up
         if (p == 2) holdoff_asked++;
         for (int n = 0; n < 240; n++) begin
            drive_item(make_random_item(), 1'b0, '0);
         end
         wait_for_results();
      end

      // drain margin beyond the input and result registers
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0) note_mismatch("responses still outstanding");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
